### design/esc_pkg.sv
// Shared types, constants and calendar helpers for the epoch-seconds converter.
package esc_pkg;

  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ZONE_OFFSET   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAYLIGHT_FLAG = 1'd1;

  localparam logic signed [16:0] ZONE_OFFSET_RESET   = 17'sd28800;
  localparam logic               DAYLIGHT_FLAG_RESET = 1'b1;

  localparam int unsigned DIVISOR_W = 18;

  localparam logic [DIVISOR_W-1:0] SECS_PER_DAY      = 18'd86400;
  localparam logic [DIVISOR_W-1:0] SECS_PER_HOUR     = 18'd3600;
  localparam logic [DIVISOR_W-1:0] SECS_PER_MIN      = 18'd60;
  localparam logic [DIVISOR_W-1:0] DAYS_PER_WEEK     = 18'd7;
  localparam logic [DIVISOR_W-1:0] DAYS_PER_CYCLE    = 18'd146097;
  localparam logic [DIVISOR_W-1:0] DAYS_1600_TO_1970 = 18'd135140;

  // Long division by a constant: one digit per pass, remainder and digit form
  // one word that is divided by multiplying with a scaled reciprocal.
  localparam int unsigned DIGIT_W = 8;
  localparam int unsigned REC_X_W = DIVISOR_W + DIGIT_W;
  localparam int unsigned REC_M_W = REC_X_W + 2;
  localparam int unsigned REC_P_W = REC_X_W + REC_M_W;

  // shift = word width plus the divisor's bit length; m = 2**shift / d + 1
  // gives the exact quotient for every word below 2**REC_X_W.
  localparam int unsigned SHIFT_DAY   = REC_X_W + 17;
  localparam int unsigned SHIFT_HOUR  = REC_X_W + 12;
  localparam int unsigned SHIFT_MIN   = REC_X_W + 6;
  localparam int unsigned SHIFT_WEEK  = REC_X_W + 3;
  localparam int unsigned SHIFT_CYCLE = REC_X_W + 18;

  localparam logic [REC_M_W-1:0] RECIP_DAY =
    REC_M_W'((64'd1 << SHIFT_DAY) / 64'(SECS_PER_DAY) + 64'd1);
  localparam logic [REC_M_W-1:0] RECIP_HOUR =
    REC_M_W'((64'd1 << SHIFT_HOUR) / 64'(SECS_PER_HOUR) + 64'd1);
  localparam logic [REC_M_W-1:0] RECIP_MIN =
    REC_M_W'((64'd1 << SHIFT_MIN) / 64'(SECS_PER_MIN) + 64'd1);
  localparam logic [REC_M_W-1:0] RECIP_WEEK =
    REC_M_W'((64'd1 << SHIFT_WEEK) / 64'(DAYS_PER_WEEK) + 64'd1);
  localparam logic [REC_M_W-1:0] RECIP_CYCLE =
    REC_M_W'((64'd1 << SHIFT_CYCLE) / 64'(DAYS_PER_CYCLE) + 64'd1);

  localparam logic [8:0] DAYS_COMMON_YEAR = 9'd365;
  localparam logic [8:0] DAYS_LEAP_YEAR   = 9'd366;
  localparam logic [3:0] LAST_MONTH       = 4'd11;
  localparam logic [1:0] LEAP_PERIOD_LAST = 2'd3;
  localparam logic [6:0] CENTURY_LAST     = 7'd99;

  typedef enum logic [2:0] {
    OP_DAY,
    OP_HOUR,
    OP_MIN,
    OP_WEEK,
    OP_CYCLE
  } div_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_RUN,
    S_YEAR,
    S_MONTH,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic    load_in;
    logic    div_load;
    logic    div_step;
    logic    div_capt;
    div_op_t op;
    logic    year_step;
    logic    month_step;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic year_fit;
    logic month_fit;
    logic out_free;
  } status_t;

  // Days in a month, months counted from 0.
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      4'd1:                      len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### design/esc_div.sv
// Constant divider shared by all conversion divisions, working one quotient digit at a time.
module esc_div #(
  parameter int unsigned TW = 37
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic                          step,
  input  esc_pkg::div_op_t              op,
  input  logic [TW-1:0]                 dividend,
  output logic [TW-1:0]                 quot,
  output logic [esc_pkg::DIVISOR_W-1:0] prem,
  output logic                          done
);
  import esc_pkg::*;

  localparam int unsigned ND = (TW + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned NW = ND * DIGIT_W;
  localparam int unsigned CW = $clog2(2 * ND + 1);

  logic [NW-1:0]        dvd_r, dvd_nxt;
  logic [DIVISOR_W-1:0] prem_r, prem_nxt;
  logic [DIGIT_W-1:0]   qd_r, qd_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [REC_X_W-1:0]   x, qprod;
  logic [DIVISOR_W-1:0] dvs;
  logic [REC_M_W-1:0]   recip;
  logic [REC_P_W-1:0]   prod;
  logic [DIGIT_W-1:0]   qd;

  // Partial remainder with the next dividend digit appended.
  assign x = {prem_r, dvd_r[NW-1 -: DIGIT_W]};

  always_comb begin
    case (op)
      OP_HOUR:  begin dvs = SECS_PER_HOUR;  recip = RECIP_HOUR;  end
      OP_MIN:   begin dvs = SECS_PER_MIN;   recip = RECIP_MIN;   end
      OP_WEEK:  begin dvs = DAYS_PER_WEEK;  recip = RECIP_WEEK;  end
      OP_CYCLE: begin dvs = DAYS_PER_CYCLE; recip = RECIP_CYCLE; end
      default:  begin dvs = SECS_PER_DAY;   recip = RECIP_DAY;   end
    endcase
  end

  assign prod = REC_P_W'(x) * REC_P_W'(recip);

  always_comb begin
    case (op)
      OP_HOUR:  qd = prod[SHIFT_HOUR +: DIGIT_W];
      OP_MIN:   qd = prod[SHIFT_MIN +: DIGIT_W];
      OP_WEEK:  qd = prod[SHIFT_WEEK +: DIGIT_W];
      OP_CYCLE: qd = prod[SHIFT_CYCLE +: DIGIT_W];
      default:  qd = prod[SHIFT_DAY +: DIGIT_W];
    endcase
  end

  assign qprod = REC_X_W'(qd_r) * REC_X_W'(dvs);

  // Even count: register the quotient digit; odd count: shift it in and
  // keep the new partial remainder.
  always_comb begin
    dvd_nxt  = dvd_r;
    prem_nxt = prem_r;
    qd_nxt   = qd_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      dvd_nxt  = NW'(dividend);
      prem_nxt = '0;
      cnt_nxt  = CW'(2 * ND);
    end else if (step && (cnt_r != '0)) begin
      cnt_nxt = cnt_r - 1'b1;
      if (!cnt_r[0]) begin
        qd_nxt = qd;
      end else begin
        dvd_nxt  = {dvd_r[NW-DIGIT_W-1:0], qd_r};
        prem_nxt = DIVISOR_W'(x - qprod);
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    prem_r <= prem_nxt;
    qd_r   <= qd_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign quot = dvd_r[TW-1:0];
  assign prem = prem_r;
  assign done = (cnt_r == '0);

endmodule

### design/esc_ctrl.sv
// Sequencer that steps the datapath through divisions, year walk and month walk.
module esc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  esc_pkg::status_t status,
  output esc_pkg::cmd_t    cmd
);
  import esc_pkg::*;

  ctrl_state_t state_r, state_nxt;
  div_op_t     op_r, op_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_LOAD;
          op_nxt    = OP_DAY;
        end
      end
      S_LOAD: state_nxt = S_RUN;
      S_RUN: begin
        if (status.div_done) begin
          unique case (op_r)
            OP_DAY:   begin op_nxt = OP_HOUR;  state_nxt = S_LOAD; end
            OP_HOUR:  begin op_nxt = OP_MIN;   state_nxt = S_LOAD; end
            OP_MIN:   begin op_nxt = OP_WEEK;  state_nxt = S_LOAD; end
            OP_WEEK:  begin op_nxt = OP_CYCLE; state_nxt = S_LOAD; end
            OP_CYCLE: state_nxt = S_YEAR;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_YEAR:  if (status.year_fit) state_nxt = S_MONTH;
      S_MONTH: if (status.month_fit) state_nxt = S_DONE;
      S_DONE:  if (status.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    cmd.op   = op_r;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      S_LOAD:  cmd.div_load = 1'b1;
      S_RUN: begin
        cmd.div_step = ~status.div_done;
        cmd.div_capt = status.div_done;
      end
      S_YEAR:  cmd.year_step  = 1'b1;
      S_MONTH: cmd.month_step = 1'b1;
      S_DONE:  cmd.out_load   = status.out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_DAY;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

endmodule

### design/esc_dpath.sv
// Datapath: zone adjust, shared divider, year and month walk, config and result registers.
module esc_dpath #(
  parameter int unsigned SECONDS_WIDTH = 36
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  esc_pkg::cmd_t                  cmd,
  output esc_pkg::status_t               status,
  input  logic                           cfg_we,
  input  logic [esc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [esc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [SECONDS_WIDTH-1:0]       in_epoch_seconds,
  input  logic                           in_command,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [5:0]                     out_second,
  output logic [5:0]                     out_minute,
  output logic [4:0]                     out_hour,
  output logic [2:0]                     out_weekday,
  output logic [11:0]                    out_year_since_1900,
  output logic [8:0]                     out_day_of_year,
  output logic [3:0]                     out_month,
  output logic [4:0]                     out_day_of_month,
  output logic signed [0:0]              out_dst_state,
  output logic                           out_underflow
);
  import esc_pkg::*;

  localparam int unsigned SW = SECONDS_WIDTH;
  localparam int unsigned TW = (SW < 64) ? SW + 1 : 64;
  localparam int unsigned DW = TW - 16;

  // Configuration.
  logic signed [16:0] zone_r;
  logic               dayl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r <= ZONE_OFFSET_RESET;
      dayl_r <= DAYLIGHT_FLAG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ZONE_OFFSET:   zone_r <= $signed(cfg_wdata);
        REG_DAYLIGHT_FLAG: dayl_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Zone adjustment.
  logic [SW:0]   t_ext, mag_ext, zo_ext, sum, dif;
  logic [16:0]   mag;
  logic [TW-1:0] t_adj;
  logic          under_adj;

  assign t_ext   = {1'b0, in_epoch_seconds};
  assign mag     = 17'(~zone_r + 17'sd1);
  assign mag_ext = (SW + 1)'(mag);
  assign zo_ext  = (SW + 1)'(zone_r[15:0]);
  assign sum     = t_ext + mag_ext;
  assign dif     = t_ext - zo_ext;

  always_comb begin
    under_adj = 1'b0;
    t_adj     = t_ext[TW-1:0];
    if (in_command) begin
      if (zone_r[16]) begin
        t_adj = (SW == 64 && sum[SW]) ? '1 : sum[TW-1:0];
      end else if (t_ext >= zo_ext) begin
        t_adj = dif[TW-1:0];
      end else begin
        t_adj     = '0;
        under_adj = 1'b1;
      end
    end
  end

  // Working registers.
  logic [TW-1:0] t_r;
  logic          under_r;
  logic [DW-1:0] days_r;
  logic [16:0]   rem_r;
  logic [4:0]    hour_r;
  logic [5:0]    min_r, sec_r;
  logic [2:0]    wday_r;
  logic [11:0]   yb_r;
  logic [17:0]   r_r;
  logic [8:0]    k_r;
  logic [1:0]    mod4_r;
  logic [6:0]    mod100_r;
  logic [8:0]    yday_r;
  logic [3:0]    mon_r;

  // Divider feed.
  logic [TW-1:0]        dividend, quot;
  logic [DIVISOR_W-1:0] prem;
  logic                 div_done;

  always_comb begin
    case (cmd.op)
      OP_HOUR:  dividend = TW'(rem_r);
      OP_MIN:   dividend = TW'(rem_r[11:0]);
      OP_WEEK:  dividend = TW'(days_r);
      OP_CYCLE: dividend = TW'(days_r) + TW'(DAYS_1600_TO_1970);
      default:  dividend = t_r;
    endcase
  end

  esc_div #(.TW(TW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (cmd.div_load),
    .step     (cmd.div_step),
    .op       (cmd.op),
    .dividend (dividend),
    .quot     (quot),
    .prem     (prem),
    .done     (div_done)
  );

  // Year and month walk.
  logic       leap;
  logic [8:0] ylen;
  logic [4:0] mlen;
  logic       year_fit, month_fit;
  logic [3:0] wsum;
  logic [23:0] yb_full;

  assign leap      = ((mod4_r == '0) && (mod100_r != '0)) || (k_r == '0);
  assign ylen      = leap ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
  assign mlen      = month_len(mon_r, leap);
  assign year_fit  = r_r < 18'(ylen);
  assign month_fit = (mon_r == LAST_MONTH) || (r_r < 18'(mlen));
  assign wsum      = {1'b0, prem[2:0]} + 4'd4;
  assign yb_full   = 24'(quot[11:0]) * 24'd400 - 24'd300;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      t_r     <= t_adj;
      under_r <= under_adj;
    end
    if (cmd.div_capt) begin
      case (cmd.op)
        OP_DAY: begin
          days_r <= quot[DW-1:0];
          rem_r  <= prem[16:0];
        end
        OP_HOUR: begin
          hour_r <= quot[4:0];
          rem_r  <= prem[16:0];
        end
        OP_MIN: begin
          min_r <= quot[5:0];
          sec_r <= prem[5:0];
        end
        OP_WEEK:  wday_r <= (wsum >= 4'd7) ? 3'(wsum - 4'd7) : wsum[2:0];
        OP_CYCLE: begin
          yb_r     <= yb_full[11:0];
          r_r      <= prem;
          k_r      <= '0;
          mod4_r   <= '0;
          mod100_r <= '0;
        end
        default: ;
      endcase
    end
    if (cmd.year_step) begin
      if (year_fit) begin
        yday_r <= r_r[8:0];
        mon_r  <= '0;
      end else begin
        r_r      <= r_r - 18'(ylen);
        k_r      <= k_r + 1'b1;
        mod4_r   <= (mod4_r == LEAP_PERIOD_LAST) ? 2'd0 : mod4_r + 1'b1;
        mod100_r <= (mod100_r == CENTURY_LAST) ? 7'd0 : mod100_r + 1'b1;
      end
    end
    if (cmd.month_step && !month_fit) begin
      r_r   <= r_r - 18'(mlen);
      mon_r <= mon_r + 1'b1;
    end
  end

  // Result register.
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_second          <= sec_r;
      out_minute          <= min_r;
      out_hour            <= hour_r;
      out_weekday         <= wday_r;
      out_year_since_1900 <= yb_r + 12'(k_r);
      out_day_of_year     <= yday_r;
      out_month           <= mon_r;
      out_day_of_month    <= 5'(r_r[4:0] + 5'd1);
      out_dst_state       <= dayl_r;
      out_underflow       <= under_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign status.div_done  = div_done;
  assign status.year_fit  = year_fit;
  assign status.month_fit = month_fit;
  assign status.out_free  = !out_valid_r || !out_stall;

endmodule

### design/epoch_seconds_to_calendar_top.sv
// Top level of the epoch-seconds to Gregorian calendar converter.
//
// Converts a count of seconds since 1970-01-01 00:00:00 into second, minute,
// hour, weekday (0 is Sunday), year since 1900, day of year, month (0 is
// January) and day of month (from 1). With in_command high the configured
// zone offset is subtracted first; a result below the epoch clamps to the
// epoch and raises out_underflow. out_dst_state carries the daylight
// flag bit as is. One item is in conversion at a time: in_stall is low only while the
// converter is idle, and the finished result sits in an output register, so
// the next transfer is taken while that result still waits downstream.
// The converter divides with five passes of one constant divider (seconds per
// day, per hour, per minute, days per week, days per 400-year cycle), each
// taking one 8-bit dividend digit at a time by reciprocal multiplication, with
// a setup step before and a capture step after. It then walks the years inside
// the 400-year Gregorian cycle (up to 399), subtracting one year length per
// cycle, and the months of the year (up to 11). A stalled result holds the
// converter in its last state until the output register frees up. Write
// configuration only while the converter is idle.
module epoch_seconds_to_calendar_top #(
  parameter int unsigned SECONDS_WIDTH = 36
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration write port
  input  logic                           cfg_we,
  input  logic [esc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [esc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [SECONDS_WIDTH-1:0]       in_epoch_seconds,
  input  logic                           in_command,
  // Result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [5:0]                     out_second,
  output logic [5:0]                     out_minute,
  output logic [4:0]                     out_hour,
  output logic [2:0]                     out_weekday,
  output logic [11:0]                    out_year_since_1900,
  output logic [8:0]                     out_day_of_year,
  output logic [3:0]                     out_month,
  output logic [4:0]                     out_day_of_month,
  output logic signed [0:0]              out_dst_state,
  output logic                           out_underflow
);
  import esc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequence each transfer through the divider passes and the calendar walk.
  esc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold configuration, working values and the result register.
  esc_dpath #(.SECONDS_WIDTH(SECONDS_WIDTH)) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_epoch_seconds    (in_epoch_seconds),
    .in_command          (in_command),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_second          (out_second),
    .out_minute          (out_minute),
    .out_hour            (out_hour),
    .out_weekday         (out_weekday),
    .out_year_since_1900 (out_year_since_1900),
    .out_day_of_year     (out_day_of_year),
    .out_month           (out_month),
    .out_day_of_month    (out_day_of_month),
    .out_dst_state       (out_dst_state),
    .out_underflow       (out_underflow)
  );

endmodule
